// ===== design/jsc_pkg.sv =====
// ----------------------------------------------------------------------------
// jsc_pkg
// Shared types and constants of the joint setpoint conditioner: controller
// states, command and status bundles, register indexes and reset values.
// ----------------------------------------------------------------------------
package jsc_pkg;

	// data widths
	localparam int NUM_W  = 44;  // divider dividend / divisor
	localparam int QUOT_W = 16;  // divider quotient
	localparam int CNT_W  = $clog2(QUOT_W);
	localparam int MIX_W  = 27;  // alpha (10b signed) x angle (17b)
	localparam int LIM_W  = 25;  // alpha (9b) x limit (16b)

	localparam int IN_W   = 48;
	localparam int OUT_W  = 56;

	// rate scaling: ms per second
	localparam int MS_PER_S = 1000;

	// register indexes
	localparam logic [2:0] REG_ANGLE_ALPHA   = 3'd0;
	localparam logic [2:0] REG_LIMIT_ALPHA   = 3'd1;
	localparam logic [2:0] REG_LIMIT_FLOOR   = 3'd2;
	localparam logic [2:0] REG_LIMIT_CEILING = 3'd3;
	localparam logic [2:0] REG_POS_AT_ZERO   = 3'd4;
	localparam logic [2:0] REG_POS_AT_FULL   = 3'd5;
	localparam logic [2:0] REG_RATE_GAIN     = 3'd6;
	localparam logic [2:0] REG_PERIOD_MS     = 3'd7;

	// register reset values
	localparam logic [8:0]  RST_ANGLE_ALPHA   = 9'd102;
	localparam logic [8:0]  RST_LIMIT_ALPHA   = 9'd102;
	localparam logic [15:0] RST_LIMIT_FLOOR   = 16'd7680;
	localparam logic [15:0] RST_LIMIT_CEILING = 16'd64000;
	localparam logic [15:0] RST_POS_AT_ZERO   = 16'd0;
	localparam logic [15:0] RST_POS_AT_FULL   = 16'd8042;
	localparam logic [15:0] RST_RATE_GAIN     = 16'd2860;
	localparam logic [9:0]  RST_PERIOD_MS     = 10'd50;
	localparam logic [15:0] RST_LIMIT_STATE   = 16'd7680;

	localparam logic [8:0]  ALPHA_ONE = 9'd256;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MIX,
		ST_SMOOTH,
		ST_DIFF,
		ST_RATE_MUL,
		ST_RATE_SCALE,
		ST_RATE_DIV,
		ST_RATE_WAIT,
		ST_CLAMP,
		ST_LIM_MUL,
		ST_LIM_SUM,
		ST_POS_MUL,
		ST_POS_ROUND,
		ST_POS_RECIP,
		ST_OUT
	} jsc_state_t;

	typedef struct packed {
		logic load_in;
		logic mix;
		logic smooth;
		logic diff;
		logic rate_mul;
		logic rate_scale;
		logic div_rate;
		logic clamp;
		logic lim_mul;
		logic lim_sum;
		logic pos_mul;
		logic pos_round;
		logic pos_recip;
		logic out_load;
	} jsc_cmd_t;

	typedef struct packed {
		logic due;
		logic div_done;
		logic out_free;
	} jsc_stat_t;

endpackage

// ===== design/joint_setpoint_conditioner_core.sv =====
// ----------------------------------------------------------------------------
// joint_setpoint_conditioner_core
// Joint angle smoothing, position mapping and rate-based velocity limit.
// One tick is in flight at a time: the next input beat is taken only once
// the previous result is loaded. The rate divider pass is the longest step when
// the limit updates; position uses a reciprocal multiply.
// A result waiting in the output register does not block the next input beat.
// Reset: async active low; config to defaults, filter state cleared, limit 7680.
// ----------------------------------------------------------------------------
module joint_setpoint_conditioner_core import jsc_pkg::*; #(
	parameter int FULL_SCALE_DEG = 90
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [2:0]       cfg_index,
	input  logic [15:0]      cfg_wdata,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [IN_W-1:0]  s_axis_tdata,   // raw_angle[8:0], now_ms[40:9]
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [OUT_W-1:0] m_axis_tdata    // target_position[15:0],
	                                         // vel_limit[31:16],
	                                         // smoothed_angle[48:32]
);

	jsc_cmd_t  cmd;
	jsc_stat_t stat;

	jsc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	jsc_datapath #(
		.FULL_SCALE_DEG (FULL_SCALE_DEG)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_raw    (s_axis_tdata[8:0]),
		.in_now    (s_axis_tdata[40:9]),
		.cmd       (cmd),
		.stat      (stat),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_data  (m_axis_tdata)
	);

endmodule

// ===== design/jsc_divider.sv =====
// ----------------------------------------------------------------------------
// jsc_divider
// Restoring divider, one quotient bit per cycle, QUOT_W quotient bits per divide.
// Flags overflow when the quotient would not fit in QUOT_W bits.
// ----------------------------------------------------------------------------
module jsc_divider import jsc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [NUM_W-1:0]  dividend,
	input  logic [NUM_W-1:0]  divisor,
	output logic              done,
	output logic [QUOT_W-1:0] quot,
	output logic              ovf
);

	localparam int SH_W = NUM_W + QUOT_W;

	logic              busy_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [NUM_W-1:0]  rem_q;
	logic [SH_W-2:0]   dvs_q;
	logic [QUOT_W-1:0] quot_q;
	logic              ovf_q;
	logic [SH_W-2:0]   rem_x;
	logic              ge;

	assign rem_x = (SH_W-1)'(rem_q);
	assign ge    = rem_x >= dvs_q;
	assign done  = busy_q && (cnt_q == '0);
	assign quot  = quot_q;
	assign ovf   = ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(QUOT_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			dvs_q <= {divisor, (QUOT_W-1)'(0)};
			ovf_q <= SH_W'(dividend) >= {divisor, QUOT_W'(0)};
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= NUM_W'(rem_x - dvs_q);
			end
			quot_q <= {quot_q[QUOT_W-2:0], ge};
			dvs_q  <= dvs_q >> 1;
		end
	end

endmodule

// ===== design/jsc_datapath.sv =====
// ----------------------------------------------------------------------------
// jsc_datapath
// Config registers, filter state, multipliers, rate divider and the output
// register. Each step is strobed by the controller.
// ----------------------------------------------------------------------------
module jsc_datapath import jsc_pkg::*; #(
	parameter int FULL_SCALE_DEG = 90
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_wdata,
	input  logic signed [8:0]  in_raw,
	input  logic [31:0]        in_now,
	input  jsc_cmd_t           cmd,
	output jsc_stat_t          stat,
	input  logic               out_ready,
	output logic               out_valid,
	output logic [OUT_W-1:0]   out_data
);

	localparam logic [15:0] FULL_Q = 16'(FULL_SCALE_DEG * 256);
	localparam logic [15:0] HALF_Q = 16'(FULL_SCALE_DEG * 128);
	// ceil(2^32 / FULL_SCALE_DEG); exact floor divide for 24-bit numerators
	localparam logic [32:0] POS_RECIP = 33'(((longint'(1) << 32) +
		longint'(FULL_SCALE_DEG) - longint'(1)) / longint'(FULL_SCALE_DEG));

	// config registers
	logic [8:0]         angle_alpha_q, limit_alpha_q;
	logic [15:0]        limit_floor_q, limit_ceiling_q, rate_gain_q;
	logic signed [15:0] pos_zero_q, pos_full_q;
	logic [9:0]         period_q;

	// filter state
	logic               primed_q;
	logic signed [16:0] smooth_q, last_smooth_q;
	logic [31:0]        last_upd_q;
	logic [15:0]        limit_q;

	// work registers
	logic signed [8:0]       raw_q;
	logic [31:0]             now_q, dt_q;
	logic                    due_q;
	logic signed [MIX_W-1:0] mix_a_q, mix_b_q;
	logic [16:0]             ad_q;
	logic [32:0]             prod_q;
	logic [NUM_W-1:0]        num_q;
	logic [15:0]             tgt_q;
	logic [LIM_W-1:0]        lim_a_q, lim_b_q;
	logic signed [33:0]      pnum_q;
	logic [23:0]             pn_q;
	logic [15:0]             pos_q;
	logic                    out_valid_q;
	logic [OUT_W-1:0]        out_data_q;

	// combinational
	logic [8:0]         a_eff, a_inv, b_eff, b_inv;
	logic signed [16:0] raw_x;
	logic signed [27:0] mix_sum;
	logic signed [19:0] mix_shift;
	logic signed [16:0] mix_sat;
	logic [9:0]         period_eff;
	logic [31:0]        dt_next;
	logic signed [17:0] sdiff;
	logic [16:0]        ad_next;
	logic               div_start;
	logic [NUM_W-1:0]   div_dividend, div_divisor;
	logic               div_done, div_ovf;
	logic [QUOT_W-1:0]  div_quot;
	logic [33:0]        pmag;
	logic [56:0]        pprod;
	logic [15:0]        tgt_lo, tgt_hi, tgt_next;
	logic [25:0]        lim_sum;
	logic [17:0]        lim_new;
	logic [15:0]        lim_sat;
	logic [15:0]        sc;
	logic signed [16:0] pdiff;
	logic signed [17:0] qs, psum;
	logic signed [15:0] pos_sat;

	assign a_eff = (angle_alpha_q > ALPHA_ONE) ? ALPHA_ONE : angle_alpha_q;
	assign a_inv = ALPHA_ONE - a_eff;
	assign b_eff = (limit_alpha_q > ALPHA_ONE) ? ALPHA_ONE : limit_alpha_q;
	assign b_inv = ALPHA_ONE - b_eff;

	assign raw_x = {raw_q, 8'b0};

	// floor((mix + 128) / 256), halves toward +inf
	assign mix_sum   = 28'(mix_a_q) + 28'(mix_b_q) + 28'sd128;
	assign mix_shift = mix_sum[27:8];
	always_comb begin
		if (mix_shift < -20'sd65536) begin
			mix_sat = -17'sd65536;
		end else if (mix_shift > 20'sd65535) begin
			mix_sat = 17'sd65535;
		end else begin
			mix_sat = mix_shift[16:0];
		end
	end

	assign period_eff = (period_q == '0) ? 10'd1 : period_q;
	assign dt_next    = now_q - last_upd_q;

	assign sdiff   = 18'(smooth_q) - 18'(last_smooth_q);
	assign ad_next = sdiff[17] ? 17'(-sdiff) : sdiff[16:0];

	// rate divider: (|ds| * 1000 * gain + dt * 2048) / (dt * 4096)
	assign div_start    = cmd.div_rate;
	assign div_dividend = num_q;
	assign div_divisor  = NUM_W'({dt_q, 12'b0});

	jsc_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quot     (div_quot),
		.ovf      (div_ovf)
	);

	// floor first, ceiling wins; an oversized quotient is above any ceiling
	assign tgt_lo   = (div_quot < limit_floor_q) ? limit_floor_q : div_quot;
	assign tgt_hi   = (tgt_lo > limit_ceiling_q) ? limit_ceiling_q : tgt_lo;
	assign tgt_next = div_ovf ? limit_ceiling_q : tgt_hi;

	assign lim_sum = 26'(lim_a_q) + 26'(lim_b_q) + 26'd128;
	assign lim_new = lim_sum[25:8];
	assign lim_sat = (lim_new > 18'd65535) ? 16'hFFFF : lim_new[15:0];

	always_comb begin
		if (smooth_q < 17'sd0) begin
			sc = '0;
		end else if (smooth_q > $signed({1'b0, FULL_Q})) begin
			sc = FULL_Q;
		end else begin
			sc = smooth_q[15:0];
		end
	end
	assign pdiff = 17'(pos_full_q) - 17'(pos_zero_q);

	// (|num| + full/2) / (deg * 256) = ((|num| + full/2) >> 8) / deg
	assign pmag  = pnum_q[33] ? 34'(-pnum_q) : 34'(pnum_q);
	assign pprod = 57'(pn_q) * 57'(POS_RECIP);

	// round half away from zero: sign applied to the magnitude quotient
	assign qs   = pnum_q[33] ? -$signed({2'b0, pos_q}) : $signed({2'b0, pos_q});
	assign psum = 18'(pos_zero_q) + qs;
	always_comb begin
		if (psum < -18'sd32768) begin
			pos_sat = -16'sd32768;
		end else if (psum > 18'sd32767) begin
			pos_sat = 16'sd32767;
		end else begin
			pos_sat = psum[15:0];
		end
	end

	assign stat.due      = due_q;
	assign stat.div_done = div_done;
	assign stat.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// config and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_alpha_q   <= RST_ANGLE_ALPHA;
			limit_alpha_q   <= RST_LIMIT_ALPHA;
			limit_floor_q   <= RST_LIMIT_FLOOR;
			limit_ceiling_q <= RST_LIMIT_CEILING;
			pos_zero_q      <= RST_POS_AT_ZERO;
			pos_full_q      <= RST_POS_AT_FULL;
			rate_gain_q     <= RST_RATE_GAIN;
			period_q        <= RST_PERIOD_MS;
			primed_q        <= 1'b0;
			smooth_q        <= '0;
			last_smooth_q   <= '0;
			last_upd_q      <= '0;
			limit_q         <= RST_LIMIT_STATE;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_ANGLE_ALPHA:   angle_alpha_q   <= cfg_wdata[8:0];
					REG_LIMIT_ALPHA:   limit_alpha_q   <= cfg_wdata[8:0];
					REG_LIMIT_FLOOR:   limit_floor_q   <= cfg_wdata;
					REG_LIMIT_CEILING: limit_ceiling_q <= cfg_wdata;
					REG_POS_AT_ZERO:   pos_zero_q      <= cfg_wdata;
					REG_POS_AT_FULL:   pos_full_q      <= cfg_wdata;
					REG_RATE_GAIN:     rate_gain_q     <= cfg_wdata;
					REG_PERIOD_MS:     period_q        <= cfg_wdata[9:0];
				endcase
			end
			if (cmd.smooth) begin
				primed_q <= 1'b1;
				smooth_q <= primed_q ? mix_sat : raw_x;
			end
			if (cmd.lim_sum) begin
				limit_q       <= lim_sat;
				last_upd_q    <= now_q;
				last_smooth_q <= smooth_q;
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			raw_q <= in_raw;
			now_q <= in_now;
		end
		if (cmd.mix) begin
			mix_a_q <= MIX_W'($signed({1'b0, a_eff})) * MIX_W'(raw_x);
			mix_b_q <= MIX_W'($signed({1'b0, a_inv})) * MIX_W'(smooth_q);
			dt_q    <= dt_next;
			due_q   <= dt_next >= 32'(period_eff);
		end
		if (cmd.diff) begin
			ad_q <= ad_next;
		end
		if (cmd.rate_mul) begin
			prod_q <= 33'(ad_q) * 33'(rate_gain_q);
		end
		if (cmd.rate_scale) begin
			// |ds| * 1000 * gain + dt * 4096 / 2
			num_q <= NUM_W'(prod_q) * NUM_W'(MS_PER_S) + NUM_W'({dt_q, 11'b0});
		end
		if (cmd.clamp) begin
			tgt_q <= tgt_next;
		end
		if (cmd.lim_mul) begin
			lim_a_q <= LIM_W'(b_eff) * LIM_W'(tgt_q);
			lim_b_q <= LIM_W'(b_inv) * LIM_W'(limit_q);
		end
		if (cmd.pos_mul) begin
			pnum_q <= 34'(pdiff) * 34'($signed({1'b0, sc}));
		end
		if (cmd.pos_round) begin
			// |num| + full/2 stays below 2^32
			pn_q <= 24'((pmag + 34'(HALF_Q)) >> 8);
		end
		if (cmd.pos_recip) begin
			pos_q <= pprod[47:32];
		end
		if (cmd.out_load) begin
			out_data_q <= {7'b0, smooth_q, limit_q, pos_sat};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== design/jsc_ctrl.sv =====
// ----------------------------------------------------------------------------
// jsc_ctrl
// Sequencer for one tick: smoothing, optional limit update through the
// divider, position interpolation by reciprocal multiply, output load.
// ----------------------------------------------------------------------------
module jsc_ctrl import jsc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  jsc_stat_t stat,
	output jsc_cmd_t  cmd
);

	jsc_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_MIX;
				end
			end
			ST_MIX: begin
				cmd.mix = 1'b1;
				state_d = ST_SMOOTH;
			end
			ST_SMOOTH: begin
				cmd.smooth = 1'b1;
				state_d    = ST_DIFF;
			end
			ST_DIFF: begin
				cmd.diff = 1'b1;
				state_d  = stat.due ? ST_RATE_MUL : ST_POS_MUL;
			end
			ST_RATE_MUL: begin
				cmd.rate_mul = 1'b1;
				state_d      = ST_RATE_SCALE;
			end
			ST_RATE_SCALE: begin
				cmd.rate_scale = 1'b1;
				state_d        = ST_RATE_DIV;
			end
			ST_RATE_DIV: begin
				cmd.div_rate = 1'b1;
				state_d      = ST_RATE_WAIT;
			end
			ST_RATE_WAIT: begin
				if (stat.div_done) begin
					state_d = ST_CLAMP;
				end
			end
			ST_CLAMP: begin
				cmd.clamp = 1'b1;
				state_d   = ST_LIM_MUL;
			end
			ST_LIM_MUL: begin
				cmd.lim_mul = 1'b1;
				state_d     = ST_LIM_SUM;
			end
			ST_LIM_SUM: begin
				cmd.lim_sum = 1'b1;
				state_d     = ST_POS_MUL;
			end
			ST_POS_MUL: begin
				cmd.pos_mul = 1'b1;
				state_d     = ST_POS_ROUND;
			end
			ST_POS_ROUND: begin
				cmd.pos_round = 1'b1;
				state_d       = ST_POS_RECIP;
			end
			ST_POS_RECIP: begin
				cmd.pos_recip = 1'b1;
				state_d       = ST_OUT;
			end
			ST_OUT: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== design/jsc_checker.sv =====
// ----------------------------------------------------------------------------
// jsc_checker
// Port-level checks of the conditioner: one tick in flight at a time, result
// handoff returns to ready, stalled result beat holds.
// ----------------------------------------------------------------------------
module jsc_checker import jsc_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             s_axis_tvalid,
	input logic             s_axis_tready,
	input logic             m_axis_tvalid,
	input logic             m_axis_tready,
	input logic [OUT_W-1:0] m_axis_tdata
);

	// accepted beat occupies the block
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken while a tick is in flight");

	// no result can appear right after an input beat
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
		else $error("result appeared one cycle after input beat");

	// a new result means the tick is done and input is open again
	a_ready_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> s_axis_tready)
		else $error("result presented while still busy");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result beat changed");

endmodule

bind joint_setpoint_conditioner_core jsc_checker u_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

// ===== verif/tb_joint_setpoint_conditioner_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_joint_setpoint_conditioner_core
// Self-checking bench for the joint setpoint conditioner. Angle/timestamp
// ticks go in through the input stream, and a bit-accurate predictor works out
// the smoothed angle, the mapped motor position and the filtered velocity
// limit. Directed ticks cover the corners, then register sets are randomized
// and timestamp walks are streamed with random bursts, gaps and output stalls.
// ----------------------------------------------------------------------------
module tb_joint_setpoint_conditioner_core;
	import jsc_pkg::*;

	localparam int     FULL_DEG        = 90;
	localparam longint TIMEOUT_CYCLES  = 1_000_000;
	localparam int     RANDOM_PHASES   = 8;
	localparam int     ITEMS_PER_PHASE = 125;

	typedef struct packed {
		logic signed [8:0] raw_angle;
		logic [31:0]       now_ms;
		logic              hold;     // wait until all results are back before this beat
	} tick_t;

	typedef struct packed {
		logic signed [15:0] target_position;
		logic [15:0]        vel_limit;
		logic signed [16:0] smoothed_angle;
	} setpoint_t;

	typedef struct packed {
		logic [8:0]         angle_alpha;
		logic [8:0]         limit_alpha;
		logic [15:0]        limit_floor;
		logic [15:0]        limit_ceiling;
		logic signed [15:0] pos_zero;
		logic signed [15:0] pos_full;
		logic [15:0]        rate_gain;
		logic [9:0]         period_ms;
	} regs_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic [2:0]       cfg_index = REG_ANGLE_ALPHA;
	logic [15:0]      cfg_wdata = '0;
	logic             s_axis_tvalid = 1'b0;
	logic             s_axis_tready;
	logic [IN_W-1:0]  s_axis_tdata = '0;
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b0;
	logic [OUT_W-1:0] m_axis_tdata;

	// predictor copy of the registers and filter state
	regs_t       regs;
	bit          primed;
	longint      smooth_q8;
	longint      rate_ref_angle;
	logic [31:0] rate_ref_ms;
	longint      limit_q8;

	tick_t     tick_q[$];
	setpoint_t setpoint_q[$];
	tick_t     beat_now;
	setpoint_t expected_sp;

	int     burst_left = 0;
	int     gap_left = 0;
	int     stall_mode = 0;
	int     stall_run = 0;
	int     mismatches = 0;
	int     ticks_sent = 0;
	int     results_checked = 0;
	int     rate_updates = 0;
	int     settings = 0;
	longint cycles = 0;

	joint_setpoint_conditioner_core #(
		.FULL_SCALE_DEG(FULL_DEG)
	) DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),   // raw_angle[8:0], now_ms[40:9]
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)    // target_position[15:0], vel_limit[31:16],
		                                 // smoothed_angle[48:32]
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// one control tick: smoothing, rate-based limit update when due, position mapping
	function automatic setpoint_t condition_tick(tick_t t);
		longint          raw, a, b, period, mix, d, sc, num, q;
		longint unsigned ad, den, tgt, lim;
		logic [31:0]     dt;
		setpoint_t       r;
		raw = longint'(t.raw_angle) * 256;
		a = (regs.angle_alpha > 256) ? 256 : regs.angle_alpha;
		b = (regs.limit_alpha > 256) ? 256 : regs.limit_alpha;
		period = (regs.period_ms == 0) ? 1 : regs.period_ms;
		if (!primed) begin
			smooth_q8 = raw;
			primed = 1'b1;
		end else begin
			mix = a * raw + (256 - a) * smooth_q8 + 128;
			smooth_q8 = mix >>> 8;
			if (smooth_q8 > 65535) smooth_q8 = 65535;
			if (smooth_q8 < -65536) smooth_q8 = -65536;
		end
		dt = t.now_ms - rate_ref_ms;
		if (dt >= period) begin
			d = smooth_q8 - rate_ref_angle;
			ad = (d < 0) ? -d : d;
			den = 64'(dt) * 4096;
			tgt = (ad * 1000 * regs.rate_gain + den / 2) / den;
			if (tgt < regs.limit_floor) tgt = regs.limit_floor;
			if (tgt > regs.limit_ceiling) tgt = regs.limit_ceiling;
			lim = (b * tgt + (256 - b) * limit_q8 + 128) >> 8;
			limit_q8 = (lim > 65535) ? 65535 : lim;
			rate_ref_ms = t.now_ms;
			rate_ref_angle = smooth_q8;
			rate_updates++;
		end
		sc = (smooth_q8 < 0) ? 0 : ((smooth_q8 > FULL_DEG * 256) ? FULL_DEG * 256 : smooth_q8);
		num = (longint'(regs.pos_full) - longint'(regs.pos_zero)) * sc;
		// halves away from zero
		if (num >= 0) q = (num + FULL_DEG * 128) / (FULL_DEG * 256);
		else q = -((-num + FULL_DEG * 128) / (FULL_DEG * 256));
		q = longint'(regs.pos_zero) + q;
		if (q > 32767) q = 32767;
		if (q < -32768) q = -32768;
		r.target_position = q[15:0];
		r.vel_limit = limit_q8[15:0];
		r.smoothed_angle = smooth_q8[16:0];
		return r;
	endfunction

	function automatic int unsigned spread(int unsigned lo, int unsigned hi);
		case ($urandom_range(0, 7))
			0: return lo;
			1: return hi;
			default: return $urandom_range(lo, hi);
		endcase
	endfunction

	task automatic flag_mismatch(string what, longint got, longint want);
		mismatches++;
		if (mismatches <= 25) begin
			$display("mismatch at result %0d: %s got %0d, expected %0d",
				results_checked, what, got, want);
		end
	endtask

	task automatic queue_tick(int raw, logic [31:0] now, bit hold);
		tick_t t;
		t.raw_angle = 9'(raw);
		t.now_ms = now;
		t.hold = hold;
		tick_q.push_back(t);
	endtask

	// registers are only written with the block idle
	task automatic apply_regs(regs_t v);
		@(posedge clk);
		cfg_we <= 1'b1; cfg_index <= REG_ANGLE_ALPHA;   cfg_wdata <= 16'(v.angle_alpha);
		@(posedge clk);
		cfg_index <= REG_LIMIT_ALPHA;   cfg_wdata <= 16'(v.limit_alpha);
		@(posedge clk);
		cfg_index <= REG_LIMIT_FLOOR;   cfg_wdata <= v.limit_floor;
		@(posedge clk);
		cfg_index <= REG_LIMIT_CEILING; cfg_wdata <= v.limit_ceiling;
		@(posedge clk);
		cfg_index <= REG_POS_AT_ZERO;   cfg_wdata <= v.pos_zero;
		@(posedge clk);
		cfg_index <= REG_POS_AT_FULL;   cfg_wdata <= v.pos_full;
		@(posedge clk);
		cfg_index <= REG_RATE_GAIN;     cfg_wdata <= v.rate_gain;
		@(posedge clk);
		cfg_index <= REG_PERIOD_MS;     cfg_wdata <= 16'(v.period_ms);
		@(posedge clk);
		cfg_we <= 1'b0;
		regs = v;
		settings++;
	endtask

	task automatic drain();
		while (tick_q.size() != 0 || s_axis_tvalid || setpoint_q.size() != 0) @(posedge clk);
	endtask

	// input driver: bursts of beats separated by random gaps
	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				setpoint_q.push_back(condition_tick(beat_now));
				ticks_sent++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (gap_left != 0) begin
					gap_left--;
					s_axis_tvalid <= 1'b0;
				end else if (tick_q.size() != 0 && !(tick_q[0].hold && setpoint_q.size() != 0)) begin
					beat_now = tick_q.pop_front();
					s_axis_tdata <= {7'd0, beat_now.now_ms, beat_now.raw_angle};
					s_axis_tvalid <= 1'b1;
					if (burst_left > 0) burst_left--;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					end
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// output monitor and stall pattern
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (setpoint_q.size() == 0) begin
					flag_mismatch("result beat with no tick outstanding", m_axis_tdata[15:0], 0);
				end else begin
					expected_sp = setpoint_q.pop_front();
					if (m_axis_tdata[15:0] !== expected_sp.target_position)
						flag_mismatch("target_position", $signed(m_axis_tdata[15:0]),
							expected_sp.target_position);
					if (m_axis_tdata[31:16] !== expected_sp.vel_limit)
						flag_mismatch("vel_limit", m_axis_tdata[31:16],
							expected_sp.vel_limit);
					if (m_axis_tdata[48:32] !== expected_sp.smoothed_angle)
						flag_mismatch("smoothed_angle", $signed(m_axis_tdata[48:32]),
							expected_sp.smoothed_angle);
				end
				results_checked++;
			end
			if (stall_run == 0) begin
				stall_mode = $urandom_range(0, 3);
				stall_run = $urandom_range(8, 200);
			end else begin
				stall_run--;
			end
			case (stall_mode)
				2: m_axis_tready <= ($urandom_range(0, 1) == 0);
				3: m_axis_tready <= ($urandom_range(0, 7) == 0);
				default: m_axis_tready <= 1'b1;
			endcase
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > TIMEOUT_CYCLES) begin
			$display("timed out after %0d cycles, %0d results outstanding",
				cycles, setpoint_q.size());
			$display("[joint_setpoint_conditioner_core] ERROR");
			$finish;
		end
	end

	initial begin
		regs_t       v;
		int          per;
		int          angle;
		int          sel;
		logic [31:0] clock_ms;

		regs.angle_alpha = 9'd102;
		regs.limit_alpha = 9'd102;
		regs.limit_floor = 16'd7680;
		regs.limit_ceiling = 16'd64000;
		regs.pos_zero = 16'sd0;
		regs.pos_full = 16'sd8042;
		regs.rate_gain = 16'd2860;
		regs.period_ms = 10'd50;
		primed = 1'b0;
		smooth_q8 = 0;
		rate_ref_angle = 0;
		rate_ref_ms = '0;
		limit_q8 = 7680;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: first tick, exact period, timestamp wrap
		queue_tick(255, 32'd10, 1'b0);
		queue_tick(-256, 32'd60, 1'b0);
		queue_tick(0, 32'd61, 1'b0);
		queue_tick(255, 32'hFFFF_FFFF, 1'b0);
		queue_tick(255, 32'd30, 1'b0);
		queue_tick(-1, 32'd49, 1'b0);
		drain();

		// alpha above one, zero period, crossed limits, widest position span
		v = '{angle_alpha: 9'd511, limit_alpha: 9'd0, limit_floor: 16'd65535,
			limit_ceiling: 16'd0, pos_zero: -16'sd32768, pos_full: 16'sd32767,
			rate_gain: 16'd65535, period_ms: 10'd0};
		apply_regs(v);
		queue_tick(90, 32'd100, 1'b0);
		queue_tick(-256, 32'd100, 1'b0);
		queue_tick(255, 32'd101, 1'b0);
		queue_tick(128, 32'd0, 1'b0);
		drain();

		// frozen smoothing, full limit weight, reversed mapping, zero gain
		v = '{angle_alpha: 9'd0, limit_alpha: 9'd256, limit_floor: 16'd0,
			limit_ceiling: 16'd65535, pos_zero: 16'sd32767, pos_full: -16'sd32768,
			rate_gain: 16'd0, period_ms: 10'd1000};
		apply_regs(v);
		queue_tick(200, 32'd2000, 1'b0);
		queue_tick(-100, 32'd2999, 1'b0);
		queue_tick(45, 32'd3000, 1'b0);
		queue_tick(0, 32'd3000, 1'b0);
		drain();

		// no smoothing lag, alpha above one on the limit, longest period
		v = '{angle_alpha: 9'd256, limit_alpha: 9'd511, limit_floor: 16'd0,
			limit_ceiling: 16'd65535, pos_zero: 16'sd0, pos_full: 16'sd8042,
			rate_gain: 16'd65535, period_ms: 10'd1023};
		apply_regs(v);
		queue_tick(255, 32'd4023, 1'b0);
		queue_tick(-256, 32'd5046, 1'b0);
		queue_tick(60, 32'd5046, 1'b0);
		queue_tick(90, 32'd6069, 1'b0);
		drain();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			v.angle_alpha = 9'(spread(0, 280));
			v.limit_alpha = 9'(spread(0, 280));
			v.limit_floor = 16'(spread(0, 20000));
			v.limit_ceiling = 16'(spread(10000, 65535));
			v.pos_zero = 16'(spread(0, 65535));
			v.pos_full = 16'(spread(0, 65535));
			v.rate_gain = 16'(spread(0, 65535));
			v.period_ms = ($urandom_range(0, 7) == 0) ? 10'(spread(0, 1023)) : 10'(spread(1, 100));
			apply_regs(v);
			per = (v.period_ms == 0) ? 1 : int'(v.period_ms);
			clock_ms = ($urandom_range(0, 2) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 4 * per)
				: $urandom();
			angle = int'($urandom_range(0, 511)) - 256;
			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				// mostly a slow walk, some jumps and end stops
				sel = $urandom_range(0, 19);
				if (sel < 12) begin
					angle = angle + int'($urandom_range(0, 40)) - 20;
					if (angle > 255) angle = 255;
					if (angle < -256) angle = -256;
				end else if (sel < 17) begin
					angle = int'($urandom_range(0, 511)) - 256;
				end else begin
					angle = sel[0] ? 255 : -256;
				end
				sel = $urandom_range(0, 19);
				if (sel < 16) clock_ms = clock_ms + $urandom_range(0, 2 * per + 1);
				else if (sel < 19) clock_ms = clock_ms + $urandom_range(0, 3);
				else clock_ms = $urandom();
				// one held beat mid-phase, more at random
				queue_tick(angle, clock_ms,
					(k == ITEMS_PER_PHASE / 2) || ($urandom_range(0, 149) == 0));
			end
			drain();
		end

		repeat (60) @(posedge clk);
		$display("ticks: %0d sent, %0d results checked across %0d register sets",
			ticks_sent, results_checked, settings);
		$display("velocity limit updates predicted: %0d, mismatches: %0d",
			rate_updates, mismatches);
		if (mismatches == 0) begin
			$display("[joint_setpoint_conditioner_core] OK");
		end else begin
			$display("[joint_setpoint_conditioner_core] ERROR");
		end
		$finish;
	end

endmodule
